[rtl/core/bta_pkg.sv]
// ---------------------------------------------------------------------------
// bta_pkg
// Shared types and constants for the boundary-tag heap allocator.
// ---------------------------------------------------------------------------
package bta_pkg;

   // heap geometry
   localparam int unsigned HEAP_BYTES = 65536;
   localparam int unsigned TAG_COUNT  = HEAP_BYTES / 4;
   localparam int unsigned IDX_W      = $clog2(TAG_COUNT);
   localparam int unsigned BRK_W      = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned ADDR_W     = BRK_W + 2;
   localparam int unsigned TAG_W      = 18;
   localparam int unsigned CHUNK_W    = 17;

   localparam logic [TAG_W-1:0]  MIN_BLOCK  = TAG_W'(16);
   localparam logic [ADDR_W-1:0] LIST_START = ADDR_W'(8);

   // action codes
   localparam logic [1:0] ACT_INIT  = 2'd0;
   localparam logic [1:0] ACT_ALLOC = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_ZERO   = 2'd1;
   localparam logic [1:0] ST_NOMEM  = 2'd2;

   // tag memory access group
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic [TAG_W-1:0] wr_data;
      logic [IDX_W-1:0] rd_idx;
   } tag_port_type;

   // one finished result
   typedef struct packed {
      logic        valid;
      logic [15:0] payload_address;
      logic [1:0]  status;
   } result_type;

endpackage

[rtl/core/bta_tag_ram.sv]
// ---------------------------------------------------------------------------
// bta_tag_ram
// Tag word store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bta_tag_ram (
   input  logic                         clock,
   input  bta_pkg::tag_port_type        port,
   output logic [bta_pkg::TAG_W-1:0]    rd_data
);
   import bta_pkg::*;

   logic [TAG_W-1:0] mem [TAG_COUNT];

   // write port
   always_ff @(posedge clock) begin
      if (port.wr_en) begin
         mem[port.wr_idx] <= port.wr_data;
      end
   end

   // read port, data registered from rd_idx
   always_ff @(posedge clock) begin
      rd_data <= mem[port.rd_idx];
   end

endmodule

[rtl/core/bta_seq.sv]
// ---------------------------------------------------------------------------
// bta_seq
// Action sequencer: init, first-fit walk, grow, merge, carve and free, all
// as read and write steps on the tag memory.
// ---------------------------------------------------------------------------
module bta_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     in_action,
   input  logic [15:0]                    in_request,
   input  logic [15:0]                    in_address,
   input  logic [bta_pkg::CHUNK_W-1:0]    chunk_cfg,
   output logic                           idle,
   output bta_pkg::tag_port_type          port,
   input  logic [bta_pkg::TAG_W-1:0]      rd_data,
   output bta_pkg::result_type            result
);
   import bta_pkg::*;

   typedef enum logic [17:0] {
      S_IDLE     = 18'h00001,
      S_INIT     = 18'h00002,
      S_GROW     = 18'h00004,
      S_GROW_WR  = 18'h00008,
      S_MRG0     = 18'h00010,
      S_MRG1     = 18'h00020,
      S_MRG2     = 18'h00040,
      S_MRG3     = 18'h00080,
      S_MRG_WR2  = 18'h00100,
      S_WALK0    = 18'h00200,
      S_WALK1    = 18'h00400,
      S_CARVE0   = 18'h00800,
      S_CARVE1   = 18'h01000,
      S_CARVE_WR = 18'h02000,
      S_FREE0    = 18'h04000,
      S_FREE1    = 18'h08000,
      S_FREE_WR  = 18'h10000,
      S_DONE     = 18'h20000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         act_ff, act_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic [BRK_W-1:0]   brk_ff, brk_in;
   logic [ADDR_W-1:0]  bp_ff, bp_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic [TAG_W-1:0]   asize_ff, asize_in;
   logic [TAG_W-1:0]   gb_ff, gb_in;
   logic [TAG_W-1:0]   size_ff, size_in;
   logic [TAG_W-1:0]   pf_ff, pf_in;
   logic               split_ff, split_in;
   logic [ADDR_W-1:0]  w2a_ff, w2a_in;
   logic [TAG_W-1:0]   w2d_ff, w2d_in;
   logic [15:0]        pay_ff, pay_in;
   logic [1:0]         stat_ff, stat_in;
   logic               oor_ff, oor_in;

   logic [ADDR_W-1:0]  rd_addr, wr_addr;
   logic [TAG_W-1:0]   wr_data;
   logic               wr_req;
   logic [TAG_W-1:0]   rd;
   logic [TAG_W-1:0]   rs;
   logic [TAG_W-1:0]   chunk;
   logic [TAG_W-1:0]   req_asize;
   logic [16:0]        grow_w2;
   logic [TAG_W-1:0]   grow_size;
   logic [TAG_W-1:0]   grow_room;
   logic [TAG_W-1:0]   psize, nsize;

   // read data, zero beyond the store
   assign rd = oor_ff ? '0 : rd_data;
   assign rs = {rd[TAG_W-1:3], 3'b000};

   assign chunk = ({1'b0, chunk_cfg} < MIN_BLOCK) ? MIN_BLOCK : {1'b0, chunk_cfg};
   assign req_asize = (in_request <= 16'd8) ? MIN_BLOCK :
                      ((TAG_W'(in_request) + TAG_W'(15)) & ~TAG_W'(7));

   // growth rounded to an even number of words
   assign grow_w2   = (17'(gb_ff[TAG_W-1:2]) + 17'd1) >> 1;
   assign grow_size = {grow_w2[TAG_W-4:0], 3'b000};
   assign grow_room = TAG_W'(HEAP_BYTES) - TAG_W'(brk_ff);

   assign psize = {pf_ff[TAG_W-1:3], 3'b000};
   assign nsize = rs;

   // sequencer
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      cnt_in   = cnt_ff;
      brk_in   = brk_ff;
      bp_in    = bp_ff;
      ptr_in   = ptr_ff;
      asize_in = asize_ff;
      gb_in    = gb_ff;
      size_in  = size_ff;
      pf_in    = pf_ff;
      split_in = split_ff;
      w2a_in   = w2a_ff;
      w2d_in   = w2d_ff;
      pay_in   = pay_ff;
      stat_in  = stat_ff;
      rd_addr  = '0;
      wr_addr  = '0;
      wr_data  = '0;
      wr_req   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_in  = in_action;
               pay_in  = '0;
               stat_in = ST_DONE;
               cnt_in  = '0;
               state_in = S_DONE;
               case (in_action)
                  ACT_INIT: begin
                     state_in = S_INIT;
                  end
                  ACT_ALLOC: begin
                     if (in_request == '0) begin
                        stat_in = ST_ZERO;
                     end else if (brk_ff == '0) begin
                        stat_in = ST_NOMEM;
                     end else begin
                        asize_in = req_asize;
                        ptr_in   = LIST_START;
                        state_in = S_WALK0;
                     end
                  end
                  ACT_FREE: begin
                     if (brk_ff != '0 && in_address[2:0] == 3'b000 &&
                         in_address >= 16'd16 && BRK_W'(in_address) < brk_ff) begin
                        bp_in    = ADDR_W'(in_address);
                        state_in = S_FREE0;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // padding, prologue header/footer, epilogue
         S_INIT: begin
            wr_req  = 1'b1;
            wr_addr = ADDR_W'({cnt_ff, 2'b00});
            case (cnt_ff)
               2'd1, 2'd2: wr_data = TAG_W'(9);
               2'd3:       wr_data = TAG_W'(1);
               default:    wr_data = '0;
            endcase
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               brk_in   = BRK_W'(16);
               gb_in    = chunk;
               state_in = S_GROW;
            end
         end

         S_GROW: begin
            if (grow_size > grow_room) begin
               pay_in   = '0;
               stat_in  = ST_NOMEM;
               state_in = S_DONE;
            end else begin
               bp_in    = ADDR_W'(brk_ff);
               size_in  = grow_size;
               brk_in   = brk_ff + BRK_W'(grow_size);
               cnt_in   = '0;
               state_in = S_GROW_WR;
            end
         end

         // new block header, footer, new epilogue
         S_GROW_WR: begin
            wr_req = 1'b1;
            cnt_in = cnt_ff + 2'd1;
            case (cnt_ff)
               2'd0: begin
                  wr_addr = bp_ff - ADDR_W'(4);
                  wr_data = size_ff;
               end
               2'd1: begin
                  wr_addr = bp_ff + ADDR_W'(size_ff) - ADDR_W'(8);
                  wr_data = size_ff;
               end
               default: begin
                  wr_addr  = bp_ff + ADDR_W'(size_ff) - ADDR_W'(4);
                  wr_data  = TAG_W'(1);
                  state_in = S_MRG0;
               end
            endcase
         end

         S_MRG0: begin
            rd_addr  = bp_ff - ADDR_W'(4);
            state_in = S_MRG1;
         end

         S_MRG1: begin
            size_in  = rs;
            rd_addr  = bp_ff - ADDR_W'(8);
            state_in = S_MRG2;
         end

         S_MRG2: begin
            pf_in    = rd;
            rd_addr  = bp_ff + ADDR_W'(size_ff) - ADDR_W'(4);
            state_in = S_MRG3;
         end

         // coalesce with free neighbors
         S_MRG3: begin
            state_in = S_MRG_WR2;
            wr_req   = 1'b1;
            if (pf_ff[0] && rd[0]) begin
               wr_req = 1'b0;
               if (act_ff == ACT_ALLOC) begin
                  state_in = S_CARVE0;
               end else begin
                  stat_in  = ST_DONE;
                  pay_in   = '0;
                  state_in = S_DONE;
               end
            end else if (pf_ff[0]) begin
               wr_addr = bp_ff - ADDR_W'(4);
               wr_data = size_ff + nsize;
               w2a_in  = bp_ff + ADDR_W'(size_ff) + ADDR_W'(nsize) - ADDR_W'(8);
               w2d_in  = size_ff + nsize;
            end else if (rd[0]) begin
               wr_addr = bp_ff + ADDR_W'(size_ff) - ADDR_W'(8);
               wr_data = size_ff + psize;
               w2a_in  = bp_ff - ADDR_W'(psize) - ADDR_W'(4);
               w2d_in  = size_ff + psize;
               bp_in   = bp_ff - ADDR_W'(psize);
            end else begin
               wr_addr = bp_ff - ADDR_W'(psize) - ADDR_W'(4);
               wr_data = size_ff + psize + nsize;
               w2a_in  = bp_ff + ADDR_W'(size_ff) + ADDR_W'(nsize) - ADDR_W'(8);
               w2d_in  = size_ff + psize + nsize;
               bp_in   = bp_ff - ADDR_W'(psize);
            end
         end

         S_MRG_WR2: begin
            wr_req  = 1'b1;
            wr_addr = w2a_ff;
            wr_data = w2d_ff;
            if (act_ff == ACT_ALLOC) begin
               state_in = S_CARVE0;
            end else begin
               stat_in  = ST_DONE;
               pay_in   = '0;
               state_in = S_DONE;
            end
         end

         // first-fit walk: S_WALK0 reads a block header, S_WALK1 checks it
         S_WALK0: begin
            rd_addr  = ptr_ff - ADDR_W'(4);
            state_in = S_WALK1;
         end

         S_WALK1: begin
            if (rs == '0) begin
               gb_in    = (asize_ff > chunk) ? asize_ff : chunk;
               state_in = S_GROW;
            end else if (!rd[0] && rs >= asize_ff) begin
               bp_in    = ptr_ff;
               state_in = S_CARVE0;
            end else begin
               ptr_in   = ptr_ff + ADDR_W'(rs);
               state_in = S_WALK0;
            end
         end

         S_CARVE0: begin
            rd_addr  = bp_ff - ADDR_W'(4);
            state_in = S_CARVE1;
         end

         S_CARVE1: begin
            size_in  = rs;
            cnt_in   = '0;
            wr_req   = 1'b1;
            wr_addr  = bp_ff - ADDR_W'(4);
            state_in = S_CARVE_WR;
            if ((ADDR_W'(rs)) < (ADDR_W'(asize_ff) + ADDR_W'(MIN_BLOCK))) begin
               split_in = 1'b0;
               wr_data  = {rs[TAG_W-1:1], 1'b1};
            end else begin
               split_in = 1'b1;
               wr_data  = {asize_ff[TAG_W-1:1], 1'b1};
            end
         end

         S_CARVE_WR: begin
            wr_req = 1'b1;
            cnt_in = cnt_ff + 2'd1;
            if (!split_ff) begin
               wr_addr = bp_ff + ADDR_W'(size_ff) - ADDR_W'(8);
               wr_data = {size_ff[TAG_W-1:1], 1'b1};
            end else begin
               case (cnt_ff)
                  2'd0: begin
                     wr_addr = bp_ff + ADDR_W'(asize_ff) - ADDR_W'(8);
                     wr_data = {asize_ff[TAG_W-1:1], 1'b1};
                  end
                  2'd1: begin
                     wr_addr = bp_ff + ADDR_W'(asize_ff) - ADDR_W'(4);
                     wr_data = size_ff - asize_ff;
                  end
                  default: begin
                     wr_addr = bp_ff + ADDR_W'(size_ff) - ADDR_W'(8);
                     wr_data = size_ff - asize_ff;
                  end
               endcase
            end
            if (!split_ff || cnt_ff == 2'd2) begin
               pay_in   = bp_ff[15:0];
               stat_in  = ST_DONE;
               state_in = S_DONE;
            end
         end

         S_FREE0: begin
            rd_addr  = bp_ff - ADDR_W'(4);
            state_in = S_FREE1;
         end

         // validate header, clear allocated bit
         S_FREE1: begin
            if (rd[0] && rs >= MIN_BLOCK &&
                (ADDR_W'(bp_ff) + ADDR_W'(rs)) <= ADDR_W'(brk_ff)) begin
               size_in  = rs;
               wr_req   = 1'b1;
               wr_addr  = bp_ff - ADDR_W'(4);
               wr_data  = rs;
               state_in = S_FREE_WR;
            end else begin
               stat_in  = ST_DONE;
               state_in = S_DONE;
            end
         end

         S_FREE_WR: begin
            wr_req   = 1'b1;
            wr_addr  = bp_ff + ADDR_W'(size_ff) - ADDR_W'(8);
            wr_data  = size_ff;
            state_in = S_MRG0;
         end

         S_DONE: begin
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign oor_in = (rd_addr[ADDR_W-1:IDX_W+2] != '0);

   // memory port
   always_comb begin
      port.wr_en   = wr_req && (wr_addr[ADDR_W-1:IDX_W+2] == '0);
      port.wr_idx  = wr_addr[IDX_W+1:2];
      port.wr_data = wr_data;
      port.rd_idx  = rd_addr[IDX_W+1:2];
   end

   assign idle = (state_ff == S_IDLE);
   assign result.valid           = (state_ff == S_DONE);
   assign result.payload_address = pay_ff;
   assign result.status          = stat_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         brk_ff   <= '0;
      end else begin
         state_ff <= state_in;
         brk_ff   <= brk_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      cnt_ff   <= cnt_in;
      bp_ff    <= bp_in;
      ptr_ff   <= ptr_in;
      asize_ff <= asize_in;
      gb_ff    <= gb_in;
      size_ff  <= size_in;
      pf_ff    <= pf_in;
      split_ff <= split_in;
      w2a_ff   <= w2a_in;
      w2d_ff   <= w2d_in;
      pay_ff   <= pay_in;
      stat_ff  <= stat_in;
      oor_ff   <= oor_in;
   end

`ifndef NO_ASSERTIONS
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !port.wr_en)
      else $error("tag write while idle");

   a_brk_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(brk_ff) <= HEAP_BYTES))
      else $error("break past heap end");

   a_done_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> (state_ff == S_IDLE))
      else $error("result held more than one cycle");

   a_start_leaves: assert property (@(posedge clock) disable iff (reset)
      (start && state_ff == S_IDLE) |=> (state_ff != S_IDLE))
      else $error("accepted action not started");
`endif

endmodule

[rtl/core/boundary_tag_heap_allocator_top.sv]
// ---------------------------------------------------------------------------
// boundary_tag_heap_allocator_top
// First-fit boundary-tag heap allocator over a 64 KiB heap.
// ---------------------------------------------------------------------------
// Usage:
//   req_* beats carry one action (init, allocate, free); each gives exactly
//   one rsp_* beat with the payload address and a status code.
//   csr_* writes the growth chunk size; write it only while the block is idle.
// Steps from the accepting edge to rsp_tvalid, one action at a time:
//   init      4 tag writes, growth check, 3 growth writes and merge check;
//             it stops at the growth check when the first growth fails
//   free      header read and check, header and footer writes, merge check,
//             plus 2 merge writes when it merges with a free neighbor; frees
//             are rejected at the address check or at the header check
//   allocate  a header read per block on the first-fit walk, end marker included,
//             carve (2 more writes on a split), growth if no block fits; refusals on accept
// Throughput: one action in flight; the next req beat is accepted once the
//   previous rsp beat has been taken.
// Reset clears the break (heap not set up) and the chunk size to 4096; tag
// memory is not cleared, so init must run before use.
// When rsp_tready is low the result waits in the output register and no new
// request is accepted until it is taken.
// ---------------------------------------------------------------------------
module boundary_tag_heap_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // action[1:0], request_bytes[17:2], block_address[33:18]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // payload_address[15:0], status[17:16]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data
);
   import bta_pkg::*;

   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_pay_ff, rsp_pay_in;
   logic [1:0]         rsp_stat_ff, rsp_stat_in;
   logic               seq_idle;
   logic               start;
   tag_port_type       port;
   logic [TAG_W-1:0]   ram_rdata;
   result_type         result;

   // configuration register
   assign csr_ready = 1'b1;
   assign chunk_in  = (csr_valid && csr_ready) ? csr_data : chunk_ff;

   // request intake
   assign req_tready = seq_idle && !rsp_valid_ff;
   assign start      = req_tvalid && req_tready;

   bta_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .in_action  (req_tdata[1:0]),
      .in_request (req_tdata[17:2]),
      .in_address (req_tdata[33:18]),
      .chunk_cfg  (chunk_ff),
      .idle       (seq_idle),
      .port       (port),
      .rd_data    (ram_rdata),
      .result     (result)
   );

   bta_tag_ram u_ram (
      .clock   (clock),
      .port    (port),
      .rd_data (ram_rdata)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_pay_in   = result.payload_address;
         rsp_stat_in  = result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_stat_ff, rsp_pay_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         chunk_ff     <= CHUNK_W'(4096);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         chunk_ff     <= chunk_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pay_ff  <= rsp_pay_in;
      rsp_stat_ff <= rsp_stat_in;
   end

endmodule
